@@ sv/csi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_pkg
// shared constants of the cubic sample interpolator
// ----------------------------------------------------------------------------
package csi_pkg;

   localparam int FRAC_W   = 16;
   localparam int COEF_W   = 38;
   localparam int PROD_W   = COEF_W + FRAC_W + 1;
   localparam int CSR_IDX_W = 2;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE_STEP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 2'd2;

   localparam logic [31:0] INVERSE_STEP_RESET = 32'd65536;
   localparam logic [31:0] INDEX_OFFSET_RESET = 32'd196608;
   localparam logic [10:0] SAMPLE_COUNT_RESET = 11'd1024;

endpackage

@@ sv/csi_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module csi_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/cubic_sample_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_sample_interpolator
// catmull-rom interpolation over a store of q16.16 samples
// ----------------------------------------------------------------------------
// One item is taken in every clock cycle; busy is always low. A query item
// gives its result strobe on rsp_valid after the last pipeline register, a load
// item gives none. The rate is set by the pipeline: one multiplier stage for
// the position, four copies of the sample store so that the four neighbours
// are read in a single cycle, and three multiply and add steps of the Horner
// evaluation, each in stages of its own. Loads write the store at the same
// pipeline stage where queries read it, so items see the store in the order
// they were taken. The result has no back pressure and must be taken when the
// strobe is high.
// ----------------------------------------------------------------------------
module cubic_sample_interpolator #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_func,
   input  logic [9:0]                     req_sample_index,
   input  logic signed [31:0]             req_sample_value,
   input  logic                           req_sample_invalid,
   input  logic signed [31:0]             req_query_time,
   output logic                           rsp_valid,
   output logic signed [31:0]             rsp_interp_value,
   output logic                           rsp_interp_invalid,
   input  logic                           csr_write_enable,
   input  logic [csi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_write_data
);

   import csi_pkg::*;

   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int NW = $clog2(MAX_SAMPLES + 1);
   localparam int IW = $clog2(MAX_SAMPLES + 6);
   localparam int XW = IW + FRAC_W;
   localparam int PW = IW + 2;

   // configuration
   logic [31:0] inverse_step_ff;
   logic [31:0] index_offset_ff;
   logic [10:0] sample_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inverse_step_ff <= INVERSE_STEP_RESET;
         index_offset_ff <= INDEX_OFFSET_RESET;
         sample_count_ff <= SAMPLE_COUNT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_INVERSE_STEP: inverse_step_ff <= csr_write_data;
            CSR_INDEX_OFFSET: index_offset_ff <= csr_write_data;
            CSR_SAMPLE_COUNT: sample_count_ff <= csr_write_data[10:0];
            default: ;
         endcase
      end
   end

   // effective sample count in [1, MAX_SAMPLES]
   logic [NW-1:0] count_n;

   always_comb begin
      if (sample_count_ff == 11'd0) begin
         count_n = NW'(1);
      end else if (32'(sample_count_ff) > 32'(MAX_SAMPLES)) begin
         count_n = NW'(MAX_SAMPLES);
      end else begin
         count_n = NW'(sample_count_ff);
      end
   end

   assign busy = 1'b0;

   // stage 1: input registers
   logic               s1_valid_ff;
   logic               s1_func_ff;
   logic [9:0]         s1_index_ff;
   logic signed [31:0] s1_value_ff;
   logic               s1_bad_ff;
   logic signed [31:0] s1_time_ff;

   // stage 2: position product
   logic               s2_valid_ff;
   logic               s2_func_ff;
   logic [9:0]         s2_index_ff;
   logic signed [31:0] s2_value_ff;
   logic               s2_bad_ff;
   logic signed [64:0] s2_prod_ff;

   // stage 3: index and fraction, store access
   logic               s3_valid_ff;
   logic               s3_func_ff;
   logic [9:0]         s3_index_ff;
   logic signed [31:0] s3_value_ff;
   logic               s3_bad_ff;
   logic [IW-1:0]      s3_i_ff;
   logic [15:0]        s3_u_ff;

   // stage 4: neighbours from the store
   logic               s4_valid_ff;
   logic [15:0]        s4_u_ff;

   // stage 5 onwards: horner evaluation
   logic                     s5_valid_ff;
   logic                     s5_inv_ff;
   logic [15:0]              s5_u_ff;
   logic signed [COEF_W-1:0] s5_a_ff;
   logic signed [COEF_W-1:0] s5_b_ff;
   logic signed [COEF_W-1:0] s5_c_ff;
   logic signed [COEF_W-1:0] s5_d_ff;

   logic                     s6_valid_ff;
   logic                     s6_inv_ff;
   logic [15:0]              s6_u_ff;
   logic signed [PROD_W-1:0] s6_m_ff;
   logic signed [COEF_W-1:0] s6_b_ff;
   logic signed [COEF_W-1:0] s6_c_ff;
   logic signed [COEF_W-1:0] s6_d_ff;

   logic                     s7_valid_ff;
   logic                     s7_inv_ff;
   logic [15:0]              s7_u_ff;
   logic signed [COEF_W-1:0] s7_r_ff;
   logic signed [COEF_W-1:0] s7_c_ff;
   logic signed [COEF_W-1:0] s7_d_ff;

   logic                     s8_valid_ff;
   logic                     s8_inv_ff;
   logic [15:0]              s8_u_ff;
   logic signed [PROD_W-1:0] s8_m_ff;
   logic signed [COEF_W-1:0] s8_c_ff;
   logic signed [COEF_W-1:0] s8_d_ff;

   logic                     s9_valid_ff;
   logic                     s9_inv_ff;
   logic [15:0]              s9_u_ff;
   logic signed [COEF_W-1:0] s9_r_ff;
   logic signed [COEF_W-1:0] s9_d_ff;

   logic                     s10_valid_ff;
   logic                     s10_inv_ff;
   logic signed [PROD_W-1:0] s10_m_ff;
   logic signed [COEF_W-1:0] s10_d_ff;

   logic                     s11_valid_ff;
   logic                     s11_inv_ff;
   logic signed [COEF_W-1:0] s11_r_ff;

   logic                     rsp_valid_ff;
   logic signed [31:0]       rsp_value_ff;
   logic                     rsp_invalid_ff;

   // position: floor(step*t / 2^16) + offset, clamped to [0, (n+5)*2^16]
   logic signed [64:0] x_full;
   logic signed [64:0] x_high;
   logic [XW-1:0]      x_in;

   always_comb begin
      x_full = (s2_prod_ff >>> FRAC_W) + 65'($signed(index_offset_ff));
      x_high = $signed(65'({(IW)'(count_n) + IW'(5), 16'h0000}));
      if (x_full < 0) begin
         x_in = '0;
      end else if (x_full > x_high) begin
         x_in = XW'(x_high);
      end else begin
         x_in = XW'(x_full);
      end
   end

   // neighbour addresses clip(i-4 .. i-1, 0, n-1)
   logic [AW-1:0]      rd_addr [4];
   logic [32:0]        rd_data [4];
   logic signed [PW-1:0] pos   [4];
   logic signed [PW-1:0] pos_max;

   always_comb begin
      pos_max = $signed(PW'(count_n) - PW'(1));
      for (int j = 0; j < 4; j++) begin
         pos[j] = $signed(PW'(s3_i_ff) + PW'(j) - PW'(4));
         if (pos[j] < 0) begin
            rd_addr[j] = '0;
         end else if (pos[j] > pos_max) begin
            rd_addr[j] = AW'(pos_max);
         end else begin
            rd_addr[j] = AW'(pos[j]);
         end
      end
   end

   logic          wr_en;
   logic [AW-1:0] wr_addr;

   assign wr_en   = s3_valid_ff && (s3_func_ff == FUNC_LOAD)
                    && (32'(s3_index_ff) < 32'(MAX_SAMPLES));
   assign wr_addr = AW'(s3_index_ff);

   for (genvar g = 0; g < 4; g++) begin : g_store
      csi_ram #(
         .WIDTH (33),
         .DEPTH (MAX_SAMPLES)
      ) u_store (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data ({s3_bad_ff, s3_value_ff}),
         .rd_addr (rd_addr[g]),
         .rd_data (rd_data[g])
      );
   end

   // doubled coefficients; linear and hold cases reuse the horner path
   logic signed [COEF_W-1:0] z [4];
   logic                     zb [4];
   logic signed [COEF_W-1:0] a_in, b_in, c_in, d_in;
   logic                     inv_in;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         z[j]  = COEF_W'($signed(rd_data[j][31:0]));
         zb[j] = rd_data[j][32];
      end
      a_in   = '0;
      b_in   = '0;
      c_in   = '0;
      d_in   = '0;
      inv_in = 1'b0;
      if (zb[1]) begin
         inv_in = 1'b1;
      end else if (zb[2]) begin
         d_in = z[1] <<< 1;
      end else if (zb[0] || zb[3]) begin
         c_in = (z[2] - z[1]) <<< 1;
         d_in = z[1] <<< 1;
      end else begin
         a_in = 3 * (z[1] - z[2]) + (z[3] - z[0]);
         b_in = (z[0] <<< 1) - 5 * z[1] + (z[2] <<< 2) - z[3];
         c_in = z[2] - z[0];
         d_in = z[1] <<< 1;
      end
   end

   // saturation of floor(r/2)
   logic signed [COEF_W-1:0] half;
   logic signed [31:0]       sat_in;

   always_comb begin
      half = s11_r_ff >>> 1;
      if (half > COEF_W'(32'sh7fffffff)) begin
         sat_in = 32'sh7fffffff;
      end else if (half < -COEF_W'(64'sh80000000)) begin
         sat_in = 32'sh80000000;
      end else begin
         sat_in = 32'(half);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
         s11_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= start && !busy;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff && (s3_func_ff == FUNC_QUERY);
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= s7_valid_ff;
         s9_valid_ff  <= s8_valid_ff;
         s10_valid_ff <= s9_valid_ff;
         s11_valid_ff <= s10_valid_ff;
         rsp_valid_ff <= s11_valid_ff;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      s1_func_ff  <= req_func;
      s1_index_ff <= req_sample_index;
      s1_value_ff <= req_sample_value;
      s1_bad_ff   <= req_sample_invalid;
      s1_time_ff  <= req_query_time;

      s2_func_ff  <= s1_func_ff;
      s2_index_ff <= s1_index_ff;
      s2_value_ff <= s1_value_ff;
      s2_bad_ff   <= s1_bad_ff;
      s2_prod_ff  <= $signed({1'b0, inverse_step_ff}) * s1_time_ff;

      s3_func_ff  <= s2_func_ff;
      s3_index_ff <= s2_index_ff;
      s3_value_ff <= s2_value_ff;
      s3_bad_ff   <= s2_bad_ff;
      s3_i_ff     <= x_in[XW-1:FRAC_W];
      s3_u_ff     <= x_in[FRAC_W-1:0];

      s4_u_ff     <= s3_u_ff;

      s5_inv_ff   <= inv_in;
      s5_u_ff     <= s4_u_ff;
      s5_a_ff     <= a_in;
      s5_b_ff     <= b_in;
      s5_c_ff     <= c_in;
      s5_d_ff     <= d_in;

      s6_inv_ff   <= s5_inv_ff;
      s6_u_ff     <= s5_u_ff;
      s6_m_ff     <= s5_a_ff * $signed({1'b0, s5_u_ff});
      s6_b_ff     <= s5_b_ff;
      s6_c_ff     <= s5_c_ff;
      s6_d_ff     <= s5_d_ff;

      s7_inv_ff   <= s6_inv_ff;
      s7_u_ff     <= s6_u_ff;
      s7_r_ff     <= COEF_W'((s6_m_ff >>> FRAC_W) + PROD_W'(s6_b_ff));
      s7_c_ff     <= s6_c_ff;
      s7_d_ff     <= s6_d_ff;

      s8_inv_ff   <= s7_inv_ff;
      s8_u_ff     <= s7_u_ff;
      s8_m_ff     <= s7_r_ff * $signed({1'b0, s7_u_ff});
      s8_c_ff     <= s7_c_ff;
      s8_d_ff     <= s7_d_ff;

      s9_inv_ff   <= s8_inv_ff;
      s9_u_ff     <= s8_u_ff;
      s9_r_ff     <= COEF_W'((s8_m_ff >>> FRAC_W) + PROD_W'(s8_c_ff));
      s9_d_ff     <= s8_d_ff;

      s10_inv_ff  <= s9_inv_ff;
      s10_m_ff    <= s9_r_ff * $signed({1'b0, s9_u_ff});
      s10_d_ff    <= s9_d_ff;

      s11_inv_ff  <= s10_inv_ff;
      s11_r_ff    <= COEF_W'((s10_m_ff >>> FRAC_W) + PROD_W'(s10_d_ff));

      rsp_invalid_ff <= s11_inv_ff;
      rsp_value_ff   <= sat_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_interp_value   = rsp_value_ff;
   assign rsp_interp_invalid = rsp_invalid_ff;

endmodule
